/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked assertion on the default clock and reset names
`define ASSERT_STD(lbl, prop) \
   `ASSERT_CLK(lbl, clock, reset, prop)

`endif

/* hw/rtl/tofc_pkg.sv */
package tofc_pkg;

   localparam int POS_W        = 18;
   localparam int TIME_W       = 24;
   localparam int OUT_W        = 23;

   // magnitude of a delta fits POS_W bits, its square twice that
   localparam int SQ_W         = 2 * POS_W;
   localparam int ROOT_W       = POS_W + 1;
   localparam int RAD_W        = 2 * ROOT_W;
   localparam int REM_W        = ROOT_W + 2;

   localparam int MUL_W        = 16;
   localparam int FLIGHT_SHIFT = 20;
   localparam int PROD_W       = ROOT_W + MUL_W;
   localparam int FLIGHT_W     = PROD_W - FLIGHT_SHIFT;
   localparam int DIFF_W       = TIME_W + 1;

   localparam logic [MUL_W-1:0] FLIGHT_MUL = 16'd55962;

   localparam logic signed [POS_W-1:0] VERTEX_X_RESET = 18'sd0;
   localparam logic signed [POS_W-1:0] VERTEX_Y_RESET = 18'sd0;
   localparam logic signed [POS_W-1:0] VERTEX_Z_RESET = -18'sd2590;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_Z = 2'd2;

   typedef logic [POS_W-1:0] mag_type;

   // |a - b| for two signed positions, always fits POS_W bits
   function automatic mag_type abs_diff(logic signed [POS_W-1:0] a,
                                        logic signed [POS_W-1:0] b);
      logic signed [POS_W:0] d;
      logic        [POS_W:0] n;
      d = {a[POS_W-1], a} - {b[POS_W-1], b};
      n = d[POS_W] ? (~d + 1'b1) : d;
      return n[POS_W-1:0];
   endfunction

endpackage

/* hw/rtl/time_of_flight_correction_core.sv */
// time-of-flight correction core
//
// req channel: one hit per beat (time plus x, y, z position). rsp channel:
// one corrected time per beat, in order. csr port: write vertex x, y, z by
// index; writes to other indexes are dropped.
//
// a hit runs through delta/abs, square, sum, a 19-stage restoring square
// root (one root bit per stage), the flight-time multiply and the
// subtract/clamp stage into the output register, which drives rsp_valid.
// one beat is taken every cycle while rsp is not stalled, so throughput is
// one hit per cycle, set by the root pipeline.
//
// reset empties the pipeline and loads the default vertex. while rsp_stall
// holds a waiting result, the whole pipeline freezes and req_stall is high;
// beats still in flight are kept, nothing is dropped or repeated.
`include "assert_macros.svh"

module time_of_flight_correction_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [tofc_pkg::TIME_W-1:0]     req_hit_time,
   input  logic signed [tofc_pkg::POS_W-1:0]      req_pos_x,
   input  logic signed [tofc_pkg::POS_W-1:0]      req_pos_y,
   input  logic signed [tofc_pkg::POS_W-1:0]      req_pos_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic        [tofc_pkg::OUT_W-1:0]      rsp_corrected_time,
   input  logic                                   csr_we,
   input  logic        [tofc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [tofc_pkg::POS_W-1:0]      csr_wdata
);
   import tofc_pkg::*;

   logic advance;

   logic signed [POS_W-1:0] vertex_x_ff, vertex_y_ff, vertex_z_ff;

   // delta stage
   logic                     dlt_vld_ff;
   logic signed [TIME_W-1:0] dlt_time_ff;
   mag_type                  dlt_x_ff, dlt_y_ff, dlt_z_ff;

   // square stage
   logic                     sqr_vld_ff;
   logic signed [TIME_W-1:0] sqr_time_ff;
   logic [SQ_W-1:0]          sqr_x_ff, sqr_y_ff, sqr_z_ff;

   // root stages, index 0 is the sum stage
   logic                     rt_vld_ff  [0:ROOT_W];
   logic signed [TIME_W-1:0] rt_time_ff [0:ROOT_W];
   logic [RAD_W-1:0]         rt_rad_ff  [0:ROOT_W];
   logic [REM_W-1:0]         rt_rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0]        rt_root_ff [0:ROOT_W];

   // multiply stage
   logic                     mul_vld_ff;
   logic signed [TIME_W-1:0] mul_time_ff;
   logic [FLIGHT_W-1:0]      mul_flight_ff;
   logic [PROD_W-1:0]        mul_prod_in;

   // output stage
   logic                     rsp_valid_ff;
   logic [OUT_W-1:0]         rsp_time_ff;
   logic [OUT_W-1:0]         rsp_time_in;
   logic signed [DIFF_W-1:0] diff;

   logic [REM_W-1:0]         root_x2;
   logic                     neg_leaving;

   // whole pipeline moves unless the output beat is held
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_x_ff <= VERTEX_X_RESET;
         vertex_y_ff <= VERTEX_Y_RESET;
         vertex_z_ff <= VERTEX_Z_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VERTEX_X: vertex_x_ff <= csr_wdata;
            CSR_VERTEX_Y: vertex_y_ff <= csr_wdata;
            CSR_VERTEX_Z: vertex_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         dlt_vld_ff   <= 1'b0;
         sqr_vld_ff   <= 1'b0;
         rt_vld_ff[0] <= 1'b0;
         mul_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         dlt_vld_ff   <= req_valid;
         sqr_vld_ff   <= dlt_vld_ff;
         rt_vld_ff[0] <= sqr_vld_ff;
         mul_vld_ff   <= rt_vld_ff[ROOT_W];
         rsp_valid_ff <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dlt_time_ff <= req_hit_time;
         dlt_x_ff    <= abs_diff(req_pos_x, vertex_x_ff);
         dlt_y_ff    <= abs_diff(req_pos_y, vertex_y_ff);
         dlt_z_ff    <= abs_diff(req_pos_z, vertex_z_ff);

         sqr_time_ff <= dlt_time_ff;
         sqr_x_ff    <= SQ_W'(dlt_x_ff) * SQ_W'(dlt_x_ff);
         sqr_y_ff    <= SQ_W'(dlt_y_ff) * SQ_W'(dlt_y_ff);
         sqr_z_ff    <= SQ_W'(dlt_z_ff) * SQ_W'(dlt_z_ff);

         rt_time_ff[0] <= sqr_time_ff;
         rt_rad_ff[0]  <= RAD_W'(sqr_x_ff) + RAD_W'(sqr_y_ff) + RAD_W'(sqr_z_ff);
         rt_rem_ff[0]  <= '0;
         rt_root_ff[0] <= '0;

         mul_time_ff   <= rt_time_ff[ROOT_W];
         mul_flight_ff <= mul_prod_in[PROD_W-1:FLIGHT_SHIFT];

         rsp_time_ff   <= rsp_time_in;
      end
   end

   // one root bit per stage, most significant radicand pair first
   for (genvar j = 0; j < ROOT_W; j++) begin : g_root
      logic [REM_W+1:0] cur;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] sub;
      logic             ge;

      assign cur   = {rt_rem_ff[j], rt_rad_ff[j][2*(ROOT_W-1-j) +: 2]};
      assign trial = {2'b00, rt_root_ff[j], 2'b01};
      assign sub   = cur - trial;
      assign ge    = (cur >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_vld_ff[j+1] <= 1'b0;
         end else if (advance) begin
            rt_vld_ff[j+1] <= rt_vld_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rt_time_ff[j+1] <= rt_time_ff[j];
            rt_rad_ff[j+1]  <= rt_rad_ff[j];
            rt_rem_ff[j+1]  <= ge ? sub[REM_W-1:0] : cur[REM_W-1:0];
            rt_root_ff[j+1] <= {rt_root_ff[j][ROOT_W-2:0], ge};
         end
      end
   end

   assign mul_prod_in = PROD_W'(rt_root_ff[ROOT_W]) * PROD_W'(FLIGHT_MUL);

   // full-width subtract, then clamp negatives to zero
   assign diff        = {mul_time_ff[TIME_W-1], mul_time_ff}
                        - $signed({{(DIFF_W-FLIGHT_W){1'b0}}, mul_flight_ff});
   assign rsp_time_in = diff[DIFF_W-1] ? '0 : diff[OUT_W-1:0];

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_corrected_time = rsp_time_ff;

   assign root_x2     = {1'b0, rt_root_ff[ROOT_W], 1'b0};
   assign neg_leaving = mul_vld_ff && advance && mul_time_ff[TIME_W-1];

   // a finished root leaves a remainder no larger than twice the root
   `ASSERT_STD(a_root_rem_bound, rt_vld_ff[ROOT_W] |-> (rt_rem_ff[ROOT_W] <= root_x2))

   // a held output freezes the stage behind it
   `ASSERT_STD(a_hold_freezes, !advance |=> $stable(mul_flight_ff) && $stable(mul_vld_ff))

   // a negative hit time always leaves as zero
   `ASSERT_STD(a_neg_clamps, neg_leaving |=> rsp_valid_ff && (rsp_corrected_time == '0))

endmodule

/* tb/time_of_flight_correction_core_tb.sv */
`timescale 1ns / 1ps

module time_of_flight_correction_core_tb;
   import tofc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic [POS_W-1:0]  POS_MAX  = 18'h1FFFF;
   localparam logic [POS_W-1:0]  POS_MIN  = 18'h20000;
   localparam logic [TIME_W-1:0] TIME_MAX = 24'h7FFFFF;
   localparam logic [TIME_W-1:0] TIME_MIN = 24'h800000;

   localparam int HITS_PER_PHASE = 125;
   localparam int RANDOM_PHASES  = 6;
   localparam int IDLE_LIMIT     = 2000;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct packed {
      logic [TIME_W-1:0] hit_time;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [POS_W-1:0]  pos_z;
   } hit_type;

   typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_LIGHT, STALL_HOLD} stall_mode_type;

   class tof_scoreboard;
      longint vert_x;
      longint vert_y;
      longint vert_z;
      logic [OUT_W-1:0] due_q[$];
      int unsigned clamped;

      function new();
         vert_x  = longint'(VERTEX_X_RESET);
         vert_y  = longint'(VERTEX_Y_RESET);
         vert_z  = longint'(VERTEX_Z_RESET);
         clamped = 0;
      endfunction

      function void write_vertex(logic [CSR_IDX_W-1:0] idx, logic [POS_W-1:0] val);
         longint v;
         v = longint'($signed(val));
         case (idx)
            CSR_VERTEX_X: vert_x = v;
            CSR_VERTEX_Y: vert_y = v;
            CSR_VERTEX_Z: vert_z = v;
            default: ;
         endcase
      endfunction

      // floor square root, two bits of radicand per step
      function longint unsigned root_floor(longint unsigned n);
         longint unsigned root;
         longint unsigned probe;
         root  = 0;
         probe = 64'd1 << 62;
         while (probe > n) probe = probe >> 2;
         while (probe != 0) begin
            if (n >= root + probe) begin
               n    = n - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root = root >> 1;
            end
            probe = probe >> 2;
         end
         return root;
      endfunction

      function longint flight_time(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                   logic [POS_W-1:0] z);
         longint dx;
         longint dy;
         longint dz;
         longint unsigned span;
         dx   = longint'($signed(x)) - vert_x;
         dy   = longint'($signed(y)) - vert_y;
         dz   = longint'($signed(z)) - vert_z;
         span = root_floor(longint'(dx * dx + dy * dy + dz * dz));
         return longint'((span * FLIGHT_MUL) >> FLIGHT_SHIFT);
      endfunction

      function void note_hit(hit_type h);
         longint diff;
         diff = longint'($signed(h.hit_time)) - flight_time(h.pos_x, h.pos_y, h.pos_z);
         if (diff < 0) begin
            diff = 0;
            clamped++;
         end
         due_q.push_back(diff[OUT_W-1:0]);
      endfunction

      function bit check_result(logic [OUT_W-1:0] got, output string msg);
         logic [OUT_W-1:0] want;
         msg = "";
         if (due_q.size() == 0) begin
            msg = $sformatf("corrected_time %0d arrived with no hit in flight", got);
            return 1'b0;
         end
         want = due_q.pop_front();
         if (got !== want) begin
            msg = $sformatf("corrected_time got %0d want %0d", got, want);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function int pending();
         return due_q.size();
      endfunction
   endclass

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_stall;
   logic [TIME_W-1:0]     req_hit_time       = '0;
   logic [POS_W-1:0]      req_pos_x          = '0;
   logic [POS_W-1:0]      req_pos_y          = '0;
   logic [POS_W-1:0]      req_pos_z          = '0;
   logic                  rsp_valid;
   logic                  rsp_stall          = 1'b0;
   logic [OUT_W-1:0]      rsp_corrected_time;
   logic                  csr_we             = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index          = '0;
   logic [POS_W-1:0]      csr_wdata          = '0;

   tof_scoreboard  sb;
   int unsigned    fail_count   = 0;
   int unsigned    hits_seen    = 0;
   int unsigned    results_seen = 0;
   int unsigned    settings     = 0;
   int unsigned    idle_cycles  = 0;
   int unsigned    burst_left   = 0;
   int unsigned    stall_left   = 0;
   stall_mode_type stall_mode   = STALL_NONE;
   string          msg;

   time_of_flight_correction_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_hit_time       (req_hit_time),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_corrected_time (rsp_corrected_time),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string text);
      $display("MISMATCH at %0t: %s", $realtime, text);
      fail_count++;
   endtask

   function automatic hit_type mk(longint t, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                  logic [POS_W-1:0] z);
      hit_type h;
      h.hit_time = TIME_W'(t);
      h.pos_x    = x;
      h.pos_y    = y;
      h.pos_z    = z;
      return h;
   endfunction

   function automatic logic [POS_W-1:0] near_vertex(longint v);
      return POS_W'(v + longint'($urandom_range(4000)) - 2000);
   endfunction

   function automatic logic [POS_W-1:0] corner();
      case ($urandom_range(2))
         0:       return POS_MAX;
         1:       return POS_MIN;
         default: return '0;
      endcase
   endfunction

   function automatic hit_type random_hit();
      hit_type h;
      longint  f;
      case ($urandom_range(2))
         0: begin
            h.pos_x = POS_W'($urandom);
            h.pos_y = POS_W'($urandom);
            h.pos_z = POS_W'($urandom);
         end
         1: begin
            h.pos_x = near_vertex(sb.vert_x);
            h.pos_y = near_vertex(sb.vert_y);
            h.pos_z = near_vertex(sb.vert_z);
         end
         default: begin
            h.pos_x = corner();
            h.pos_y = corner();
            h.pos_z = corner();
         end
      endcase
      f = sb.flight_time(h.pos_x, h.pos_y, h.pos_z);
      // bias times toward the clamp boundary, where the subtract matters
      case ($urandom_range(3))
         0:       h.hit_time = TIME_W'($urandom);
         1:       h.hit_time = TIME_W'(f - 1 + longint'($urandom_range(2)));
         2:       h.hit_time = TIME_W'($urandom_range(int'(2 * f + 2)));
         default: h.hit_time = TIME_W'(longint'($urandom_range(200)) - 100);
      endcase
      return h;
   endfunction

   // one req beat, then maybe a gap when the current burst runs out
   task automatic push_hit(input hit_type h);
      int unsigned gap;
      req_valid    <= 1'b1;
      req_hit_time <= h.hit_time;
      req_pos_x    <= h.pos_x;
      req_pos_y    <= h.pos_y;
      req_pos_z    <= h.pos_z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left == 0) begin
         gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
         burst_left = $urandom_range(40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // hit time one below, at, and one above the flight time
   task automatic push_edge_trio(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                 input logic [POS_W-1:0] z);
      longint f;
      f = sb.flight_time(x, y, z);
      push_hit(mk(f - 1, x, y, z));
      push_hit(mk(f, x, y, z));
      push_hit(mk(f + 1, x, y, z));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [POS_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_vertex(idx, val);
   endtask

   // unused index goes last so an aliased decode would clobber a vertex
   task automatic program_vertex(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                 input logic [POS_W-1:0] z, input bit poke_unused);
      write_reg(CSR_VERTEX_X, x);
      write_reg(CSR_VERTEX_Y, y);
      write_reg(CSR_VERTEX_Z, z);
      if (poke_unused) write_reg(CSR_UNUSED, POS_W'($urandom));
      csr_we <= 1'b0;
      settings++;
   endtask

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(3));
         stall_left = (stall_mode == STALL_HOLD) ? $urandom_range(60, 2) : $urandom_range(80, 5);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_HALF:  rsp_stall <= ($urandom_range(1) == 1);
         STALL_LIGHT: rsp_stall <= ($urandom_range(3) == 0);
         default:     rsp_stall <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_hit(mk(longint'($signed(req_hit_time)), req_pos_x, req_pos_y, req_pos_z));
            hits_seen++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (!sb.check_result(rsp_corrected_time, msg)) report_mismatch(msg);
            results_seen++;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                        idle_cycles, sb.pending());
               $display("Test completed with failures");
               $finish;
            end
         end
      end
   end

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default vertex
      push_hit(mk(0, '0, '0, VERTEX_Z_RESET));
      push_hit(mk(TIME_MAX, '0, '0, VERTEX_Z_RESET));
      push_hit(mk(TIME_MIN, '0, '0, VERTEX_Z_RESET));
      push_hit(mk(TIME_MAX, POS_MIN, POS_MIN, POS_MIN));
      push_hit(mk(TIME_MAX, POS_MAX, POS_MAX, POS_MAX));
      push_hit(mk(-1, 18'd100, 18'd200, 18'd300));
      push_hit(mk(100, POS_MAX, POS_MAX, POS_MAX));
      push_hit(mk(0, '0, '0, '0));
      push_edge_trio(POS_MAX, POS_MIN, POS_MAX);
      wait_drained();

      // vertex at one corner, hits at the far corner give the largest delta
      program_vertex(POS_MAX, POS_MIN, POS_MAX, 1'b1);
      push_hit(mk(TIME_MAX, POS_MIN, POS_MAX, POS_MIN));
      push_hit(mk(TIME_MAX, POS_MAX, POS_MIN, POS_MAX));
      push_hit(mk(TIME_MIN, POS_MAX, POS_MIN, POS_MAX));
      push_edge_trio(POS_MIN, POS_MAX, POS_MIN);
      wait_drained();

      program_vertex(POS_MIN, POS_MAX, POS_MIN, 1'b0);
      push_hit(mk(TIME_MAX, POS_MAX, POS_MIN, POS_MAX));
      push_edge_trio(POS_MAX, POS_MIN, POS_MAX);
      wait_drained();

      program_vertex('0, '0, '0, 1'b1);
      push_hit(mk(1, '0, '0, '0));
      push_hit(mk(TIME_MAX, 18'h00001, 18'h3FFFF, 18'h00010));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // results all back before the vertex moves
         wait_drained();
         case (phase)
            0:       program_vertex(POS_MAX, POS_MAX, POS_MAX, 1'b1);
            1:       program_vertex(POS_MIN, POS_MIN, POS_MIN, 1'b0);
            2:       program_vertex('0, '0, '0, 1'b1);
            3:       program_vertex(VERTEX_X_RESET, VERTEX_Y_RESET, VERTEX_Z_RESET, 1'b0);
            default: program_vertex(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                                    $urandom_range(1) == 1);
         endcase
         repeat (HITS_PER_PHASE) push_hit(random_hit());
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d hits, %0d results, %0d vertex settings, %0d clamped to zero",
               hits_seen, results_seen, settings, sb.clamped);
      $display("corner positions, times at the flight boundary, unused csr index, random stalls");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
